// ===== hw/rtl/spfp_pkg.sv =====
package spfp_pkg;

	localparam int MAX_BINS     = 1024;
	localparam int BIN_AW       = $clog2(MAX_BINS);
	localparam int CNT_W        = BIN_AW + 1;
	localparam int MAX_FORMANTS = 64;
	localparam int FMT_W        = 7;
	localparam int POW_W        = 32;
	localparam int Q_DEPTH      = 4;
	localparam int Q_AW         = $clog2(Q_DEPTH);

	// divider geometry: quotient always fits in DIV_QW bits
	localparam int DIV_NW = 80;
	localparam int DIV_DW = 34;
	localparam int DIV_QW = 48;
	localparam int DIV_CW = $clog2(DIV_QW + 1);

	localparam logic [1:0] REG_BIN_SPACING = 2'd0;
	localparam logic [1:0] REG_TOP_FREQ    = 2'd1;
	localparam logic [1:0] REG_MAX_FMT     = 2'd2;

	typedef struct packed {
		logic [POW_W-1:0] power;
		logic             last;
	} bin_t;

	typedef struct packed {
		logic [31:0]      spacing;
		logic [31:0]      top_freq;
		logic [FMT_W-1:0] limit;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_INIT,
		ST_RD1,
		ST_RD2,
		ST_GETR,
		ST_TEST,
		ST_SQ,
		ST_DIV1,
		ST_DIV2,
		ST_FHZ,
		ST_FCAP,
		ST_RSTART,
		ST_XCHK,
		ST_XNB,
		ST_XDIV,
		ST_XHZ,
		ST_XHZ2,
		ST_BW,
		ST_NEXT,
		ST_FIN
	} scan_state_t;

endpackage

// ===== hw/rtl/spfp_front.sv =====
module spfp_front
	import spfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic signed [15:0] real_part,
	input  logic signed [15:0] imag_part,
	input  logic               last_bin,
	output logic               push,
	output bin_t               entry
);

	logic signed [31:0] re_sq;
	logic signed [31:0] im_sq;
	logic               valid_s1;
	bin_t               entry_s1;

	assign re_sq = real_part * real_part;
	assign im_sq = imag_part * imag_part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1.power <= $unsigned(re_sq) + $unsigned(im_sq);
			entry_s1.last  <= last_bin;
		end
	end

	assign push  = valid_s1;
	assign entry = entry_s1;

endmodule

// ===== hw/rtl/spfp_queue.sv =====
module spfp_queue
	import spfp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  bin_t din,
	input  logic pop,
	output bin_t dout,
	output logic empty
);

	bin_t            slots_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= din;
		end
	end

	assign dout  = slots_q[rd_ptr_q];
	assign empty = (fill_q == '0);

endmodule

// ===== hw/rtl/spfp_div.sv =====
module spfp_div
	import spfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              done,
	output logic [DIV_QW-1:0] quot,
	output logic [DIV_DW-1:0] rem
);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_QW-1:0] shreg_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_CW-1:0] steps_q;
	logic              run_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, shreg_q[DIV_QW-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q   <= 1'b1;
				steps_q <= DIV_CW'(DIV_QW);
			end else if (run_q) begin
				steps_q <= steps_q - 1'b1;
				if (steps_q == DIV_CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= DIV_DW'(dividend[DIV_NW-1:DIV_QW]);
			shreg_q <= dividend[DIV_QW-1:0];
			dvs_q   <= divisor;
		end else if (run_q) begin
			rem_q   <= fits ? DIV_DW'(trial - {1'b0, dvs_q}) : trial[DIV_DW-1:0];
			shreg_q <= {shreg_q[DIV_QW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = shreg_q;
	assign rem  = rem_q;

endmodule

// ===== hw/rtl/spfp_back.sv =====
module spfp_back
	import spfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_empty,
	input  bin_t        q_data,
	output logic        q_pop,
	output logic        result_valid,
	output logic [31:0] frequency_q8,
	output logic [31:0] bandwidth_q8,
	output logic        peak_found,
	output logic        last_result
);

	scan_state_t state_q, state_d;

	logic [POW_W-1:0]  mem [MAX_BINS];
	logic [POW_W-1:0]  rd_data_q;
	logic [BIN_AW-1:0] rd_addr;

	logic [CNT_W-1:0]  wr_cnt_q;
	logic [CNT_W-1:0]  n_q;
	logic              wr_ok;
	logic [BIN_AW-1:0] k_q;
	logic [BIN_AW-1:0] j_q;
	logic              side_q;
	logic [FMT_W-1:0]  cnt_q;
	logic [FMT_W-1:0]  limit_q;
	logic [POW_W-1:0]  pl_q, pc_q, pr_q, pj_q;
	logic              d1neg_q;
	logic [31:0]       absd1_q;
	logic [33:0]       d2_q;
	logic [31:0]       fpos_q;
	logic [31:0]       pos_q;
	logic [47:0]       m_q;
	logic [31:0]       freq_q;
	logic [39:0]       fl_q, fr_q;
	logic              pend_q;
	logic [31:0]       pend_f_q, pend_b_q;

	logic [31:0]       mul_a, mul_b;
	logic [63:0]       mul_q;

	logic              div_start;
	logic [DIV_NW-1:0] div_nd;
	logic [DIV_DW-1:0] div_dv;
	logic              div_done;
	logic [DIV_QW-1:0] div_quot;
	logic [DIV_DW-1:0] div_rem;

	logic              above;
	logic              more;
	logic              advance;
	logic [31:0]       d1_adj;
	logic [40:0]       bw_diff;
	logic [31:0]       bw_sat;
	logic [FMT_W-1:0]  lim_eff;

	spfp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_nd),
		.divisor  (div_dv),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign wr_ok   = (wr_cnt_q < CNT_W'(MAX_BINS));
	assign above   = ({rd_data_q, 16'b0} > m_q);
	assign more    = side_q ? (CNT_W'(j_q) < n_q - 1'b1) : (j_q != '0);
	assign advance = (cnt_q < limit_q) && (CNT_W'(k_q) + CNT_W'(2) < n_q);
	assign lim_eff = (cfg.limit == '0) ? FMT_W'(1) :
		(cfg.limit > FMT_W'(MAX_FORMANTS)) ? FMT_W'(MAX_FORMANTS) : cfg.limit;

	// floor of the signed parabola offset
	assign d1_adj = d1neg_q ? (32'd0 - (32'(div_quot) + 32'(div_rem != '0))) : 32'(div_quot);

	assign bw_diff = {1'b0, fr_q} - {1'b0, fl_q};
	assign bw_sat  = bw_diff[40] ? 32'd0 : (|bw_diff[39:32]) ? 32'hFFFF_FFFF : bw_diff[31:0];

	always_ff @(posedge clk) begin
		if (q_pop && wr_ok) begin
			mem[wr_cnt_q[BIN_AW-1:0]] <= q_data.power;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		rd_addr   = '0;
		q_pop     = 1'b0;
		div_start = 1'b0;
		div_nd    = '0;
		div_dv    = d2_q;
		mul_a     = cfg.spacing;
		mul_b     = fpos_q;
		unique case (state_q)
			ST_LOAD: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_data.last) begin
						state_d = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				state_d = (n_q < CNT_W'(3)) ? ST_FIN : ST_RD1;
			end
			ST_RD1: begin
				rd_addr = BIN_AW'(1);
				state_d = ST_RD2;
			end
			ST_RD2: begin
				rd_addr = BIN_AW'(2);
				state_d = ST_GETR;
			end
			ST_GETR: begin
				state_d = ST_TEST;
			end
			ST_TEST: begin
				state_d = ((pc_q > pl_q) && (pc_q >= pr_q)) ? ST_SQ : ST_NEXT;
			end
			ST_SQ: begin
				mul_a     = absd1_q;
				mul_b     = absd1_q;
				div_start = 1'b1;
				div_nd    = DIV_NW'({absd1_q, 15'b0});
				state_d   = ST_DIV1;
			end
			ST_DIV1: begin
				mul_a = absd1_q;
				mul_b = absd1_q;
				if (div_done) begin
					div_start = 1'b1;
					div_nd    = DIV_NW'({mul_q, 12'b0});
					state_d   = ST_DIV2;
				end
			end
			ST_DIV2: begin
				if (div_done) begin
					state_d = ST_FHZ;
				end
			end
			ST_FHZ: begin
				state_d = ST_FCAP;
			end
			ST_FCAP: begin
				rd_addr = k_q - 1'b1;
				state_d = ST_XCHK;
			end
			ST_RSTART: begin
				rd_addr = k_q + 1'b1;
				state_d = ST_XCHK;
			end
			ST_XCHK: begin
				if (above && more) begin
					rd_addr = side_q ? j_q + 1'b1 : j_q - 1'b1;
				end else if (above) begin
					state_d = side_q ? ST_BW : ST_RSTART;
				end else begin
					rd_addr = side_q ? j_q - 1'b1 : j_q + 1'b1;
					state_d = ST_XNB;
				end
			end
			ST_XNB: begin
				div_start = 1'b1;
				div_nd    = DIV_NW'(m_q - {pj_q, 16'b0});
				div_dv    = DIV_DW'(rd_data_q - pj_q);
				state_d   = ST_XDIV;
			end
			ST_XDIV: begin
				if (div_done) begin
					state_d = ST_XHZ;
				end
			end
			ST_XHZ: begin
				mul_b   = pos_q;
				state_d = ST_XHZ2;
			end
			ST_XHZ2: begin
				state_d = side_q ? ST_BW : ST_RSTART;
			end
			ST_BW: begin
				state_d = ST_NEXT;
			end
			ST_NEXT: begin
				if (advance) begin
					rd_addr = k_q + BIN_AW'(2);
					state_d = ST_GETR;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_LOAD;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q     <= '0;
			n_q          <= '0;
			cnt_q        <= '0;
			limit_q      <= FMT_W'(1);
			pend_q       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (q_pop) begin
				if (q_data.last) begin
					n_q      <= wr_cnt_q + CNT_W'(wr_ok);
					wr_cnt_q <= '0;
					cnt_q    <= '0;
					pend_q   <= 1'b0;
					limit_q  <= lim_eff;
				end else begin
					wr_cnt_q <= wr_cnt_q + CNT_W'(wr_ok);
				end
			end
			if (state_q == ST_BW) begin
				// the held result goes out once the next one is known
				result_valid <= pend_q;
				pend_q       <= 1'b1;
				cnt_q        <= cnt_q + 1'b1;
			end
			if (state_q == ST_FIN) begin
				result_valid <= 1'b1;
				pend_q       <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_INIT: begin
				k_q <= BIN_AW'(1);
			end
			ST_RD1: begin
				pl_q <= rd_data_q;
			end
			ST_RD2: begin
				pc_q <= rd_data_q;
			end
			ST_GETR: begin
				pr_q <= rd_data_q;
			end
			ST_TEST: begin
				d1neg_q <= (pr_q < pl_q);
				absd1_q <= (pr_q >= pl_q) ? pr_q - pl_q : pl_q - pr_q;
				d2_q    <= {1'b0, pc_q, 1'b0} - {2'b0, pl_q} - {2'b0, pr_q};
			end
			ST_DIV1: begin
				if (div_done) begin
					fpos_q <= {6'b0, k_q, 16'b0} + d1_adj;
				end
			end
			ST_DIV2: begin
				m_q    <= {1'b0, pc_q, 15'b0} + div_quot;
				side_q <= 1'b0;
			end
			ST_FCAP: begin
				freq_q <= (|mul_q[63:56]) ? 32'hFFFF_FFFF : mul_q[55:24];
				j_q    <= k_q - 1'b1;
			end
			ST_RSTART: begin
				j_q    <= k_q + 1'b1;
				side_q <= 1'b1;
			end
			ST_XCHK: begin
				pj_q <= rd_data_q;
				if (above && more) begin
					j_q <= side_q ? j_q + 1'b1 : j_q - 1'b1;
				end else if (above) begin
					if (side_q) begin
						fr_q <= {8'b0, cfg.top_freq};
					end else begin
						fl_q <= '0;
					end
				end
			end
			ST_XDIV: begin
				pos_q <= side_q ? {6'b0, j_q, 16'b0} - div_quot[31:0]
					: {6'b0, j_q, 16'b0} + div_quot[31:0];
			end
			ST_XHZ2: begin
				if (side_q) begin
					fr_q <= mul_q[63:24];
				end else begin
					fl_q <= mul_q[63:24];
				end
			end
			ST_BW: begin
				frequency_q8 <= pend_f_q;
				bandwidth_q8 <= pend_b_q;
				peak_found   <= 1'b1;
				last_result  <= 1'b0;
				pend_f_q     <= freq_q;
				pend_b_q     <= bw_sat;
			end
			ST_NEXT: begin
				if (advance) begin
					k_q  <= k_q + 1'b1;
					pl_q <= pc_q;
					pc_q <= pr_q;
				end
			end
			ST_FIN: begin
				frequency_q8 <= pend_q ? pend_f_q : 32'd0;
				bandwidth_q8 <= pend_q ? pend_b_q : 32'd0;
				peak_found   <= pend_q;
				last_result  <= 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/spectral_peak_formant_picker_core.sv =====
// bins are taken one per cycle while busy is low; the last bin raises busy
// the scan then reads the power memory through one port and shares one
// 48-step divider; interior bins are tested in turn, each peak is refined by two
// divisions and each half-power search walks bin by bin; busy falls after the final result
// each result strobe lasts one cycle and the receiver cannot stall
// arst_n clears control state and loads the register defaults; stored power is not cleared
module spectral_peak_formant_picker_core
	import spfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] real_part,
	input  logic signed [15:0] imag_part,
	input  logic               last_bin,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               result_valid,
	output logic [31:0]        frequency_q8,
	output logic [31:0]        bandwidth_q8,
	output logic               peak_found,
	output logic               last_result
);

	cfg_t cfg_q;
	logic busy_q;
	logic accept;
	logic push;
	bin_t entry;
	logic pop;
	bin_t q_data;
	logic q_empty;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spacing  <= 32'd655360;
			cfg_q.top_freq <= 32'd0;
			cfg_q.limit    <= FMT_W'(5);
			busy_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BIN_SPACING: cfg_q.spacing  <= cfg_data;
					REG_TOP_FREQ:    cfg_q.top_freq <= cfg_data;
					REG_MAX_FMT:     cfg_q.limit    <= cfg_data[FMT_W-1:0];
					default: begin
					end
				endcase
			end
			if (accept && last_bin) begin
				busy_q <= 1'b1;
			end else if (result_valid && last_result) begin
				busy_q <= 1'b0;
			end
		end
	end

	spfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.real_part (real_part),
		.imag_part (imag_part),
		.last_bin  (last_bin),
		.push      (push),
		.entry     (entry)
	);

	spfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (entry),
		.pop    (pop),
		.dout   (q_data),
		.empty  (q_empty)
	);

	spfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_data       (q_data),
		.q_pop        (pop),
		.result_valid (result_valid),
		.frequency_q8 (frequency_q8),
		.bandwidth_q8 (bandwidth_q8),
		.peak_found   (peak_found),
		.last_result  (last_result)
	);

endmodule
